// File: design/bbe_pkg.sv
package bbe_pkg;

  localparam int MAX_ORDER  = 8;
  localparam int MAX_KNOTS  = 1024;
  localparam int ORD_W      = $clog2(MAX_ORDER);
  localparam int KIDX_W     = $clog2(MAX_KNOTS);
  localparam int KNOT_W     = 32;
  localparam int DELTA_W    = KNOT_W + 1;
  localparam int DEN_W      = DELTA_W + 1;
  localparam int PROD_W     = DELTA_W + KNOT_W;
  localparam int BASIS_W    = 31;
  localparam int CFG_W      = 11;
  localparam int CNT_W      = $clog2(PROD_W + 1);

  localparam logic       CFG_SPLINE_ORDER = 1'b0;
  localparam logic       CFG_KNOT_COUNT   = 1'b1;
  localparam logic       REQ_WRITE        = 1'b0;
  localparam logic       REQ_EVAL         = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_R, ST_RD_L, ST_LD_L, ST_TERM, ST_QA, ST_QBS, ST_QB, ST_NEXT, ST_EMIT
  } st_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_st_t;

  typedef struct packed {
    logic start;
  } md_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_sts_t;

  function automatic logic signed [KNOT_W-1:0] sat32(input logic signed [DEN_W-1:0] v);
    logic signed [DEN_W-1:0] hi;
    logic signed [DEN_W-1:0] lo;
    hi = DEN_W'(32'sh7fffffff);
    lo = -(DEN_W'(34'sh80000000));
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[KNOT_W-1:0];
  endfunction

  function automatic logic [BASIS_W-1:0] clamp_basis(input logic signed [KNOT_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > 32'sh40000000) begin
      return BASIS_W'(32'h40000000);
    end
    return v[BASIS_W-1:0];
  endfunction

endpackage

// File: design/bbe_if.sv
interface bbe_in_if import bbe_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [KIDX_W-1:0]        knot_index;
  logic signed [KNOT_W-1:0] knot_value;
  logic signed [KNOT_W-1:0] eval_point;
  logic [KIDX_W-1:0]        interval_index;

  modport source (output valid, req_type, knot_index, knot_value, eval_point,
                  interval_index, input ready);
  modport sink (input valid, req_type, knot_index, knot_value, eval_point,
                interval_index, output ready);
endinterface

interface bbe_out_if import bbe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BASIS_W-1:0] basis_value;
  logic [ORD_W-1:0]   basis_index;
  logic               last;
  logic               div_error;

  modport source (output valid, basis_value, basis_index, last, div_error, input ready);
  modport sink (input valid, basis_value, basis_index, last, div_error, output ready);
endinterface

// File: design/bbe_muldiv.sv
module bbe_muldiv import bbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  md_ctl_t                   ctl,
  input  logic signed [DELTA_W-1:0] op_a,
  input  logic signed [KNOT_W-1:0]  op_b,
  input  logic signed [DEN_W-1:0]   op_den,
  output md_sts_t                   sts,
  output logic signed [KNOT_W-1:0]  quo
);

  md_st_t             st_r, st_nxt;
  logic [PROD_W-1:0]  acc_r;
  logic [PROD_W-1:0]  ma_r;
  logic [KNOT_W-1:0]  mb_r;
  logic [DEN_W-1:0]   dm_r;
  logic [DEN_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [DEN_W:0]     trial;
  logic               qbit;
  logic [DELTA_W-1:0] a_neg;
  logic [KNOT_W-1:0]  b_neg;
  logic [DEN_W-1:0]   d_neg;

  assign a_neg = -op_a;
  assign b_neg = -op_b;
  assign d_neg = -op_den;
  assign trial = {rem_r, acc_r[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, dm_r});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      MD_IDLE: if (ctl.start) st_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == CNT_W'(KNOT_W - 1)) st_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == CNT_W'(PROD_W - 1)) st_nxt = MD_DONE;
      MD_DONE: st_nxt = MD_IDLE;
      default: st_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (st_r != MD_IDLE);
    sts.done = (st_r == MD_DONE);
    if (neg_r) begin
      quo = (acc_r >= PROD_W'(64'h80000000)) ? 32'sh80000000 : -$signed(acc_r[KNOT_W-1:0]);
    end else begin
      quo = (acc_r > PROD_W'(64'h7fffffff)) ? 32'sh7fffffff : $signed(acc_r[KNOT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      MD_IDLE: begin
        if (ctl.start) begin
          acc_r <= '0;
          ma_r  <= PROD_W'(op_a[DELTA_W-1] ? a_neg : op_a);
          mb_r  <= op_b[KNOT_W-1] ? b_neg : op_b;
          dm_r  <= op_den[DEN_W-1] ? d_neg : op_den;
          neg_r <= op_a[DELTA_W-1] ^ op_b[KNOT_W-1] ^ op_den[DEN_W-1];
          cnt_r <= '0;
        end
      end
      MD_MUL: begin
        if (mb_r[0]) acc_r <= acc_r + ma_r;
        ma_r  <= {ma_r[PROD_W-2:0], 1'b0};
        mb_r  <= {1'b0, mb_r[KNOT_W-1:1]};
        cnt_r <= (cnt_r == CNT_W'(KNOT_W - 1)) ? '0 : cnt_r + 1'b1;
        rem_r <= '0;
      end
      MD_DIV: begin
        rem_r <= qbit ? DEN_W'(trial - {1'b0, dm_r}) : trial[DEN_W-1:0];
        acc_r <= {acc_r[PROD_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/bspline_basis_eval.sv
// B-spline basis evaluator. A transaction with req_type 0 writes one Q16.16 knot into the
// 1024-entry knot memory and gives no result; req_type 1 evaluates the order-k basis at
// eval_point over interval_index and returns k results, basis_index 0 to k-1, the last one
// flagged, each Q30 value clamped to [0, 1.0]. A zero denominator gives a zero term and sets
// div_error on every result of that evaluation. Knots must be written before they are used.
// An evaluation is serial: for each of the k(k-1)/2 terms one shared shift-add multiplier
// and restoring divider runs twice (32 multiply steps, 65 divide steps per run), or not at
// all when the denominator is zero, after two registered knot reads per step of the order
// recursion; then the k results are emitted in order. Input is not accepted until the last
// result is taken.
module bspline_basis_eval import bbe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bbe_in_if.sink           in_ch,
  bbe_out_if.source        out_ch
);

  st_t                       st_r, st_nxt;
  logic [3:0]                order_r;
  logic [CFG_W-1:0]          count_r;
  logic [3:0]                k_r;
  logic [KIDX_W-1:0]         last_r;
  logic signed [KNOT_W-1:0]  x_r;
  logic [KIDX_W-1:0]         lft_r;
  logic [ORD_W-1:0]          j_r, i_r, o_r;
  logic                      err_r;
  logic signed [KNOT_W-1:0]  saved_r, qa_r;
  logic signed [KNOT_W-1:0]  basis_r [MAX_ORDER];
  logic signed [DELTA_W-1:0] rd_r [MAX_ORDER];
  logic signed [DELTA_W-1:0] ld_r [MAX_ORDER];
  logic signed [KNOT_W-1:0]  knot_mem [MAX_KNOTS];
  logic signed [KNOT_W-1:0]  rdata_r;
  logic [KIDX_W-1:0]         rd_addr;
  logic [3:0]                k_cfg;
  logic [KIDX_W-1:0]         last_cfg;
  logic [KIDX_W:0]           ri_sum;
  logic signed [KIDX_W+1:0]  li_sum;
  logic [KIDX_W-1:0]         ri, li;
  logic [ORD_W-1:0]          li_pos;
  logic signed [DELTA_W-1:0] cur_dr, cur_dl;
  logic signed [DEN_W-1:0]   den;
  logic                      in_acc, out_acc;
  md_ctl_t                   md_ctl;
  md_sts_t                   md_sts;
  logic signed [KNOT_W-1:0]  md_quo;

  bbe_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (md_ctl),
    .op_a   ((st_r == ST_QBS) ? cur_dl : cur_dr),
    .op_b   (basis_r[i_r]),
    .op_den (den),
    .sts    (md_sts),
    .quo    (md_quo)
  );

  always_comb begin
    if (order_r == 4'd0) begin
      k_cfg = 4'd1;
    end else if (order_r > 4'(MAX_ORDER)) begin
      k_cfg = 4'(MAX_ORDER);
    end else begin
      k_cfg = order_r;
    end
    if (count_r == '0) begin
      last_cfg = '0;
    end else if (count_r > CFG_W'(MAX_KNOTS)) begin
      last_cfg = KIDX_W'(MAX_KNOTS - 1);
    end else begin
      last_cfg = KIDX_W'(count_r - 1'b1);
    end
    ri_sum = {1'b0, lft_r} + (KIDX_W+1)'(j_r);
    ri     = (ri_sum > {1'b0, last_r}) ? last_r : ri_sum[KIDX_W-1:0];
    li_sum = $signed({2'b0, lft_r}) + 12'sd1 - $signed({9'b0, j_r});
    if (li_sum < 0) begin
      li = '0;
    end else if (li_sum > $signed({2'b0, last_r})) begin
      li = last_r;
    end else begin
      li = li_sum[KIDX_W-1:0];
    end
    li_pos  = j_r - 1'b1 - i_r;
    cur_dr  = rd_r[i_r];
    cur_dl  = ld_r[li_pos];
    den     = DEN_W'(cur_dr) + DEN_W'(cur_dl);
    rd_addr = (st_r == ST_RD_R) ? ri : li;
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc && in_ch.req_type == REQ_EVAL) st_nxt = (k_cfg == 4'd1) ? ST_EMIT : ST_RD_R;
      end
      ST_RD_R: st_nxt = ST_RD_L;
      ST_RD_L: st_nxt = ST_LD_L;
      ST_LD_L: st_nxt = ST_TERM;
      ST_TERM: st_nxt = (den == '0) ? ST_NEXT : ST_QA;
      ST_QA:   if (md_sts.done) st_nxt = ST_QBS;
      ST_QBS:  st_nxt = ST_QB;
      ST_QB:   if (md_sts.done) st_nxt = ST_NEXT;
      ST_NEXT: begin
        if (i_r == j_r - 1'b1) begin
          st_nxt = (4'(j_r) == k_r - 1'b1) ? ST_EMIT : ST_RD_R;
        end else begin
          st_nxt = ST_TERM;
        end
      end
      ST_EMIT: if (out_acc && 4'(o_r) == k_r - 1'b1) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready        = (st_r == ST_IDLE);
    out_ch.valid       = (st_r == ST_EMIT);
    out_ch.basis_value = clamp_basis(basis_r[o_r]);
    out_ch.basis_index = o_r;
    out_ch.last        = (4'(o_r) == k_r - 1'b1);
    out_ch.div_error   = err_r;
    md_ctl.start       = (st_r == ST_TERM && den != '0) || (st_r == ST_QBS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      order_r <= 4'd4;
      count_r <= CFG_W'(8);
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPLINE_ORDER: order_r <= cfg_data[3:0];
          CFG_KNOT_COUNT:   count_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // knot memory
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == REQ_WRITE) knot_mem[in_ch.knot_index] <= in_ch.knot_value;
    rdata_r <= knot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (in_acc && in_ch.req_type == REQ_EVAL) begin
          k_r        <= k_cfg;
          last_r     <= last_cfg;
          x_r        <= in_ch.eval_point;
          lft_r      <= in_ch.interval_index;
          j_r        <= ORD_W'(1);
          o_r        <= '0;
          err_r      <= 1'b0;
          basis_r[0] <= 32'sh40000000;
        end
      end
      ST_RD_L: rd_r[j_r - 1'b1] <= DELTA_W'(rdata_r) - DELTA_W'(x_r);
      ST_LD_L: begin
        ld_r[j_r - 1'b1] <= DELTA_W'(x_r) - DELTA_W'(rdata_r);
        i_r              <= '0;
        saved_r          <= '0;
      end
      ST_TERM: begin
        if (den == '0) begin
          err_r         <= 1'b1;
          basis_r[i_r]  <= saved_r;
          saved_r       <= '0;
        end
      end
      ST_QA: if (md_sts.done) qa_r <= md_quo;
      ST_QB: begin
        if (md_sts.done) begin
          basis_r[i_r] <= sat32(DEN_W'(saved_r) + DEN_W'(qa_r));
          saved_r      <= md_quo;
        end
      end
      ST_NEXT: begin
        if (i_r == j_r - 1'b1) begin
          basis_r[j_r] <= saved_r;
          j_r          <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_EMIT: if (out_acc) o_r <= o_r + 1'b1;
      default: begin
      end
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("input open while results pending");
  a_md_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_ctl.start |-> !md_sts.busy) else $error("shared unit restarted while busy");
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> in_ch.ready) else $error("no return to idle after last");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TERM) |-> (i_r < j_r && 4'(j_r) < k_r)) else $error("step index out of range");

endmodule

// File: tb/tb_bspline_basis_eval.sv
module tb_bspline_basis_eval;
  import bbe_pkg::*;

  localparam int LIMIT = 20000000;
  localparam int FILL  = 256;

  typedef struct {
    logic                     req_type;
    logic [KIDX_W-1:0]        knot_index;
    logic signed [KNOT_W-1:0] knot_value;
    logic signed [KNOT_W-1:0] eval_point;
    logic [KIDX_W-1:0]        interval_index;
  } req_t;

  typedef struct {
    logic [BASIS_W-1:0] basis_value;
    logic [ORD_W-1:0]   basis_index;
    logic               last;
    logic               div_error;
  } basis_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bbe_in_if  in_ch();
  bbe_out_if out_ch();

  bspline_basis_eval uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  req_t   pending_reqs[$];
  basis_t expected_basis[$];

  // predictor state
  logic signed [KNOT_W-1:0] knot_mem[MAX_KNOTS];
  logic [3:0]               order_reg;
  logic [CFG_W-1:0]         count_reg;

  // stimulus-side copy of the knot vector
  logic signed [KNOT_W-1:0] gen_knots[MAX_KNOTS];

  int  errors;
  int  cycles;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  in_taken;
  bit  hold_req;
  bit  hold_done;
  int  hold_cnt;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic signed [65:0] sat_word(input logic signed [65:0] v);
    if (v > 66'sh7fffffff) return 66'sh7fffffff;
    if (v < -66'sh80000000) return -66'sh80000000;
    return v;
  endfunction

  task automatic predict_basis(input logic signed [KNOT_W-1:0] x, input logic [KIDX_W-1:0] lft);
    logic signed [65:0] bw[MAX_ORDER];
    logic signed [65:0] rd[MAX_ORDER];
    logic signed [65:0] ld[MAX_ORDER];
    logic signed [65:0] dr, dl, den, b, saved, xs, kv;
    int k, top, ri, li;
    bit err;
    basis_t r;
    err = 0;
    k = order_reg;
    if (k < 1) k = 1;
    if (k > MAX_ORDER) k = MAX_ORDER;
    top = count_reg > MAX_KNOTS ? MAX_KNOTS : count_reg;
    top = top > 0 ? top - 1 : 0;
    xs = x;
    for (int i = 0; i < MAX_ORDER; i++) bw[i] = 0;
    bw[0] = 66'sd1 <<< 30;
    for (int j = 1; j < k; j++) begin
      saved = 0;
      ri = lft + j;
      li = lft + 1 - j;
      if (ri > top) ri = top;
      if (li < 0) li = 0;
      if (li > top) li = top;
      kv = knot_mem[ri];
      rd[j-1] = kv - xs;
      kv = knot_mem[li];
      ld[j-1] = xs - kv;
      for (int i = 0; i < j; i++) begin
        dr = rd[i];
        dl = ld[j-1-i];
        den = dr + dl;
        b = bw[i];
        if (den == 0) begin
          err = 1;
          bw[i] = saved;
          saved = 0;
        end else begin
          bw[i] = sat_word(saved + sat_word((dr * b) / den));
          saved = sat_word((dl * b) / den);
        end
      end
      bw[j] = saved;
    end
    for (int i = 0; i < k; i++) begin
      b = bw[i];
      if (b < 0) b = 0;
      if (b > (66'sd1 <<< 30)) b = 66'sd1 <<< 30;
      r.basis_value = b[BASIS_W-1:0];
      r.basis_index = i[ORD_W-1:0];
      r.last = (i == k - 1);
      r.div_error = err;
      expected_basis.push_back(r);
    end
  endtask

  // input side: acceptance, prediction, config shadow
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n && cfg_we) begin
      if (cfg_index == CFG_SPLINE_ORDER) order_reg = cfg_data[3:0];
      else count_reg = cfg_data;
    end
    if (rst_n && in_taken) begin
      if (in_ch.req_type == REQ_WRITE) knot_mem[in_ch.knot_index] = in_ch.knot_value;
      else predict_basis(in_ch.eval_point, in_ch.interval_index);
    end
  end

  // result checker
  always @(posedge clk) begin
    basis_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_basis.size() == 0) begin
        report("unexpected result transaction, basis_index", out_ch.basis_index, -1);
      end else begin
        w = expected_basis.pop_front();
        if (out_ch.basis_value !== w.basis_value)
          report("basis_value", out_ch.basis_value, w.basis_value);
        if (out_ch.basis_index !== w.basis_index)
          report("basis_index", out_ch.basis_index, w.basis_index);
        if (out_ch.last !== w.last) report("last", out_ch.last, w.last);
        if (out_ch.div_error !== w.div_error)
          report("div_error", out_ch.div_error, w.div_error);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    req_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        c = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= c.req_type;
        in_ch.knot_index <= c.knot_index;
        in_ch.knot_value <= c.knot_value;
        in_ch.eval_point <= c.eval_point;
        in_ch.interval_index <= c.interval_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 1500;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_write(input int idx, input logic signed [KNOT_W-1:0] v);
    req_t c;
    c.req_type = REQ_WRITE;
    c.knot_index = idx[KIDX_W-1:0];
    c.knot_value = v;
    c.eval_point = $urandom;
    c.interval_index = $urandom;
    gen_knots[idx] = v;
    pending_reqs.push_back(c);
  endtask

  task automatic add_eval(input logic signed [KNOT_W-1:0] x, input int lft);
    req_t c;
    c.req_type = REQ_EVAL;
    c.knot_index = $urandom;
    c.knot_value = $urandom;
    c.eval_point = x;
    c.interval_index = lft[KIDX_W-1:0];
    pending_reqs.push_back(c);
  endtask

  task automatic add_random(input int n, input int cnt);
    int top, r, idx, lft;
    longint lo, hi, span, v;
    top = cnt > MAX_KNOTS ? MAX_KNOTS : cnt;
    top = top > 0 ? top - 1 : 0;
    for (int m = 0; m < n; m++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        // knot update that keeps the vector mostly ordered
        idx = $urandom_range(top);
        lo = gen_knots[idx > 0 ? idx - 1 : 0];
        hi = gen_knots[idx < MAX_KNOTS - 1 ? idx + 1 : idx];
        case ($urandom_range(3))
          0: v = lo;
          1: v = hi;
          default: v = (lo + hi) / 2;
        endcase
        add_write(idx, v[31:0]);
      end else if (r < 25) begin
        add_write($urandom_range(MAX_KNOTS - 1), $urandom);
      end else if (r < 88) begin
        lft = $urandom_range(top > 0 ? top - 1 : 0);
        lo = gen_knots[lft];
        hi = gen_knots[lft + 1 > top ? top : lft + 1];
        span = hi - lo;
        if (span <= 0) v = lo;
        else v = lo + longint'($urandom) % (span + 1);
        add_eval(v[31:0], lft);
      end else begin
        add_eval($urandom, $urandom_range(MAX_KNOTS - 1));
      end
    end
  endtask

  task automatic wait_drained(input int extra);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_basis.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_cfg(input logic idx, input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int ord, input int cnt, input int n);
    wait_drained(20);
    set_cfg(CFG_SPLINE_ORDER, ord);
    set_cfg(CFG_KNOT_COUNT, cnt);
    add_random(n, cnt);
  endtask

  initial begin
    longint acc;
    logic signed [KNOT_W-1:0] keep0, keep4;
    errors = 0;
    cycles = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 51;
    hold_req = 0;
    hold_done = 0;
    hold_cnt = 0;
    in_taken = 0;
    order_reg = 4;
    count_reg = 8;
    cfg_we = 1'b0;
    cfg_index = CFG_SPLINE_ORDER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_WRITE;
    in_ch.knot_index = '0;
    in_ch.knot_value = '0;
    in_ch.eval_point = '0;
    in_ch.interval_index = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fill the low part of the knot store with an ascending vector
    acc = -64'sd150000000;
    for (int i = 0; i < FILL; i++) begin
      add_write(i, acc[31:0]);
      acc += $urandom_range(1 << 14, 3 << 16);
    end

    // directed part at reset configuration
    add_eval(gen_knots[3], 3);
    add_eval(gen_knots[4], 3);
    add_eval(gen_knots[0], 0);
    add_eval((gen_knots[6] + gen_knots[7]) / 2, 6);
    add_eval(gen_knots[7], MAX_KNOTS - 1);
    add_eval(32'sh7fffffff, 0);
    add_eval(32'sh80000000, 5);
    keep4 = gen_knots[4];
    keep0 = gen_knots[0];
    add_write(4, gen_knots[3]);
    add_eval(gen_knots[3], 3);
    add_write(0, 32'sh80000000);
    add_eval(32'sh0, 0);
    add_write(MAX_KNOTS - 1, 32'sh7fffffff);
    add_write(MAX_KNOTS - 1, 32'sh80000000);
    add_eval(gen_knots[5], 5);
    add_write(4, keep4);
    add_write(0, keep0);
    add_eval(gen_knots[2], 2);

    // random phases
    run_phase(1, 2, 15);
    run_phase(2, FILL, 25);
    hold_req = 1;
    run_phase(3, 200, 20);
    tx_idle_pct = 51;
    rx_idle_pct = 19;
    run_phase(4, 0, 15);
    run_phase(8, FILL, 15);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(0, 17, 15);
    run_phase(15, 100, 15);
    run_phase(5, 40, 15);

    wait_drained(200);
    if (expected_basis.size() != 0) begin
      report("missing results", expected_basis.size(), 0);
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: bspline_basis_eval.f
design/bbe_pkg.sv
design/bbe_if.sv
design/bbe_muldiv.sv
design/bspline_basis_eval.sv
tb/tb_bspline_basis_eval.sv
